### hdl/escaped_packet_receiver_core_assert.svh
// Assertion macros used by the receiver's controller.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ESCAPED_PACKET_RECEIVER_CORE_ASSERT_SVH
`define ESCAPED_PACKET_RECEIVER_CORE_ASSERT_SVH

// Same-cycle implication.
`define EPR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("receiver property violated");

// Next-cycle implication.
`define EPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("receiver property violated");

`endif

### hdl/epr_pkg.sv
package epr_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       framing_error;
    logic       overrun_error;
  } epr_in_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] payload_byte;
    logic [4:0] byte_index;
    logic [4:0] payload_length;
    logic [7:0] source_id;
    logic [7:0] port_id;
    logic       last;
    logic [7:0] received_count;
    logic [7:0] accepted_count;
    logic [7:0] mismatch_count;
  } epr_out_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_BYTE     = 2'd1,
    EV_EMPTY    = 2'd2,
    EV_MISMATCH = 2'd3
  } event_kind_e;

  typedef enum logic [1:0] {
    CFG_ESCAPE  = 2'd0,
    CFG_HEADER  = 2'd1,
    CFG_END     = 2'd2,
    CFG_ADDRESS = 2'd3
  } cfg_index_e;

  localparam logic [7:0] ESCAPE_RESET  = 8'd126;
  localparam logic [7:0] HEADER_RESET  = 8'd129;
  localparam logic [7:0] END_RESET     = 8'd130;
  localparam logic [7:0] ADDRESS_RESET = 8'd48;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        load_in;
    logic        chk_load_inv;
    logic        chk_xor;
    logic        load_src;
    logic        load_port;
    logic        store_byte;
    logic        fill_dec;
    logic        inc_received;
    logic        inc_accepted;
    logic        inc_mismatch;
    logic        rd_clear;
    logic        rd_en;
    logic        rd_next;
    logic        out_load;
    event_kind_e out_kind;
  } epr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic err;
    logic is_escape;
    logic is_header;
    logic is_end;
    logic is_addr;
    logic chk_zero;
    logic fill_full;
    logic fill_gt1;
    logic rd_last;
  } epr_stat_t;

endpackage

### hdl/epr_datapath.sv
module epr_datapath
  import epr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  epr_in_t    in_data_i,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  epr_cmd_t   cmd_i,
  output epr_stat_t  stat_o,
  output epr_out_t   out_data_o
);

  localparam int unsigned IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned FW = $clog2(MAX_PAYLOAD + 1);

  epr_in_t        in_q;
  logic [7:0]     esc_q, hdr_q, end_q, addr_q;
  logic [7:0]     chk_q, chk_d;
  logic [FW-1:0]  fill_q, fill_d;
  logic [7:0]     src_q, src_d, port_q, port_d;
  logic [7:0]     rcv_q, rcv_d, acc_q, acc_d, mis_q, mis_d;
  logic           wrap;
  logic [IW-1:0]  rd_idx_q, rd_idx_d;
  logic [7:0]     rd_data_q;
  logic [7:0]     mem_q [MAX_PAYLOAD];
  epr_out_t       out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q  <= ESCAPE_RESET;
      hdr_q  <= HEADER_RESET;
      end_q  <= END_RESET;
      addr_q <= ADDRESS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ESCAPE:  esc_q  <= cfg_data_i;
        CFG_HEADER:  hdr_q  <= cfg_data_i;
        CFG_END:     end_q  <= cfg_data_i;
        CFG_ADDRESS: addr_q <= cfg_data_i;
      endcase
    end
  end

  always_comb begin
    chk_d = chk_q;
    if (cmd_i.chk_load_inv) begin
      chk_d = ~in_q.rx_byte;
    end else if (cmd_i.chk_xor) begin
      chk_d = chk_q ^ in_q.rx_byte;
    end

    fill_d = fill_q;
    if (cmd_i.load_src) begin
      fill_d = '0;
    end else if (cmd_i.store_byte) begin
      fill_d = fill_q + FW'(1);
    end else if (cmd_i.fill_dec && (fill_q != '0)) begin
      fill_d = fill_q - FW'(1);
    end

    src_d  = cmd_i.load_src  ? in_q.rx_byte : src_q;
    port_d = cmd_i.load_port ? in_q.rx_byte : port_q;

    // Any counter that wraps to zero clears all three.
    wrap  = 1'b0;
    rcv_d = rcv_q;
    acc_d = acc_q;
    mis_d = mis_q;
    if (cmd_i.inc_received) begin
      rcv_d = rcv_q + 8'd1;
      wrap  = (rcv_d == 8'd0);
    end
    if (cmd_i.inc_accepted) begin
      acc_d = acc_q + 8'd1;
      wrap  = (acc_d == 8'd0);
    end
    if (cmd_i.inc_mismatch) begin
      mis_d = mis_q + 8'd1;
      wrap  = (mis_d == 8'd0);
    end
    if (wrap) begin
      rcv_d = '0;
      acc_d = '0;
      mis_d = '0;
    end

    rd_idx_d = rd_idx_q;
    if (cmd_i.rd_clear) begin
      rd_idx_d = '0;
    end else if (cmd_i.rd_next) begin
      rd_idx_d = rd_idx_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q    <= '0;
      fill_q   <= '0;
      src_q    <= '0;
      port_q   <= '0;
      rcv_q    <= '0;
      acc_q    <= '0;
      mis_q    <= '0;
      rd_idx_q <= '0;
    end else begin
      chk_q    <= chk_d;
      fill_q   <= fill_d;
      src_q    <= src_d;
      port_q   <= port_d;
      rcv_q    <= rcv_d;
      acc_q    <= acc_d;
      mis_q    <= mis_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  // Payload store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_byte) begin
      mem_q[fill_q[IW-1:0]] <= in_q.rx_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_idx_q];
    end
  end

  always_comb begin
    stat_o.err       = in_q.framing_error | in_q.overrun_error;
    stat_o.is_escape = (in_q.rx_byte == esc_q);
    stat_o.is_header = (in_q.rx_byte == hdr_q);
    stat_o.is_end    = (in_q.rx_byte == end_q);
    stat_o.is_addr   = (in_q.rx_byte == addr_q);
    stat_o.chk_zero  = (chk_q == 8'd0);
    stat_o.fill_full = (fill_q >= FW'(MAX_PAYLOAD));
    stat_o.fill_gt1  = (fill_q > FW'(1));
    stat_o.rd_last   = ((FW'(rd_idx_q) + FW'(1)) == fill_q);
  end

  // Result beat; counters and ids always show the values after this item's update.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.event_kind     <= cmd_i.out_kind;
      out_q.source_id      <= src_d;
      out_q.port_id        <= port_d;
      out_q.received_count <= rcv_d;
      out_q.accepted_count <= acc_d;
      out_q.mismatch_count <= mis_d;
      if (cmd_i.out_kind == EV_BYTE) begin
        out_q.payload_byte   <= rd_data_q;
        out_q.byte_index     <= 5'(rd_idx_q);
        out_q.payload_length <= 5'(fill_q);
        out_q.last           <= stat_o.rd_last;
      end else begin
        out_q.payload_byte   <= '0;
        out_q.byte_index     <= '0;
        out_q.payload_length <= '0;
        out_q.last           <= 1'b1;
      end
    end
  end

  assign out_data_o = out_q;

endmodule

### hdl/epr_controller.sv
`include "escaped_packet_receiver_core_assert.svh"

module epr_controller
  import epr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  epr_stat_t stat_i,
  output epr_cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    PH_HUNT = 8'b0000_0001,
    PH_ESC  = 8'b0000_0010,
    PH_CHK  = 8'b0000_0100,
    PH_DEST = 8'b0000_1000,
    PH_SRC  = 8'b0001_0000,
    PH_PORT = 8'b0010_0000,
    PH_DATA = 8'b0100_0000,
    PH_DESC = 8'b1000_0000
  } rx_phase_e;

  typedef enum logic [3:0] {
    SEQ_IDLE = 4'b0001,
    SEQ_STEP = 4'b0010,
    SEQ_READ = 4'b0100,
    SEQ_SEND = 4'b1000
  } seq_state_e;

  rx_phase_e   phase_q, phase_d;
  seq_state_e  seq_q, seq_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;
  event_kind_e step_kind;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (seq_q == SEQ_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.out_kind = EV_NONE;
    phase_d        = phase_q;
    seq_d          = seq_q;
    step_kind      = EV_NONE;

    unique case (seq_q)
      SEQ_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          seq_d         = SEQ_STEP;
        end
      end
      SEQ_STEP: begin
        if (slot_free) begin
          if (stat_i.err) begin
            phase_d = PH_HUNT;
          end else begin
            unique case (phase_q)
              PH_HUNT: begin
                if (stat_i.is_escape) phase_d = PH_ESC;
              end
              PH_ESC: begin
                if (stat_i.is_header) begin
                  phase_d            = PH_CHK;
                  cmd_o.inc_received = 1'b1;
                end else begin
                  phase_d = PH_HUNT;
                end
              end
              PH_CHK: begin
                if (stat_i.is_escape) begin
                  phase_d = PH_ESC;
                end else begin
                  cmd_o.chk_load_inv = 1'b1;
                  phase_d            = PH_DEST;
                end
              end
              PH_DEST: begin
                // The address match wins over an escape of the same value.
                priority if (stat_i.is_addr) begin
                  cmd_o.chk_xor = 1'b1;
                  phase_d       = PH_SRC;
                end else if (stat_i.is_escape) begin
                  phase_d = PH_ESC;
                end else begin
                  phase_d = PH_HUNT;
                end
              end
              PH_SRC: begin
                if (stat_i.is_escape) begin
                  phase_d = PH_ESC;
                end else begin
                  cmd_o.chk_xor  = 1'b1;
                  cmd_o.load_src = 1'b1;
                  phase_d        = PH_PORT;
                end
              end
              PH_PORT: begin
                if (stat_i.is_escape) begin
                  phase_d = PH_ESC;
                end else begin
                  cmd_o.chk_xor   = 1'b1;
                  cmd_o.load_port = 1'b1;
                  phase_d         = PH_DATA;
                end
              end
              PH_DATA: begin
                if (stat_i.fill_full) begin
                  phase_d = PH_HUNT;
                end else begin
                  // Escapes are stored once but enter the checksum with their twin.
                  cmd_o.store_byte = 1'b1;
                  if (stat_i.is_escape) begin
                    phase_d = PH_DESC;
                  end else begin
                    cmd_o.chk_xor = 1'b1;
                  end
                end
              end
              PH_DESC: begin
                priority if (stat_i.is_escape) begin
                  cmd_o.chk_xor = 1'b1;
                  phase_d       = PH_DATA;
                end else if (stat_i.is_end) begin
                  phase_d = PH_HUNT;
                  if (stat_i.chk_zero) begin
                    // Drop the stored trailing escape.
                    cmd_o.fill_dec     = 1'b1;
                    cmd_o.inc_accepted = 1'b1;
                    step_kind          = stat_i.fill_gt1 ? EV_BYTE : EV_EMPTY;
                  end else begin
                    cmd_o.inc_mismatch = 1'b1;
                    step_kind          = EV_MISMATCH;
                  end
                end else begin
                  phase_d = PH_HUNT;
                end
              end
              default: phase_d = PH_HUNT;
            endcase
          end

          if (step_kind == EV_BYTE) begin
            cmd_o.rd_clear = 1'b1;
            seq_d          = SEQ_READ;
          end else begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_kind = step_kind;
            seq_d          = SEQ_IDLE;
          end
        end
      end
      SEQ_READ: begin
        cmd_o.rd_en = 1'b1;
        seq_d       = SEQ_SEND;
      end
      SEQ_SEND: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = EV_BYTE;
          cmd_o.rd_next  = 1'b1;
          seq_d          = stat_i.rd_last ? SEQ_IDLE : SEQ_READ;
        end
      end
      default: seq_d = SEQ_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      seq_q       <= SEQ_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
    end
  end

  `EPR_ASSERT_IMPL(a_no_beat_overwrite, cmd_o.out_load, !out_valid_q || out_ready_i)
  `EPR_ASSERT_IMPL(a_store_not_full, cmd_o.store_byte, !stat_i.fill_full)
  `EPR_ASSERT_NEXT(a_accept_starts_step, in_valid_i && in_ready_o, seq_q == SEQ_STEP)
  `EPR_ASSERT_NEXT(a_last_beat_ends_burst, (seq_q == SEQ_SEND) && cmd_o.out_load && stat_i.rd_last, seq_q == SEQ_IDLE)

endmodule

### hdl/escaped_packet_receiver_core.sv
// An input byte is registered in the accept cycle; then the deframer is updated and the result
// beat loaded into the output register, when that register is free.
// An accepted packet of n payload bytes gives n beats, paced by the payload memory's registered
// read port and by output stalls; a new byte is taken after the last beat loads.
// Reset is asynchronous, active low: it returns to hunting and clears the checksum, fill,
// source, port and counters, and restores the code registers; the payload memory is not cleared.
module escaped_packet_receiver_core
  import epr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  epr_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output epr_out_t   out_data_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  epr_cmd_t  cmd;
  epr_stat_t stat;

  epr_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  epr_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule

### bench/packet_stream_checker.sv
module packet_stream_checker
  import epr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  epr_in_t    in_data_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  epr_out_t   out_data_i,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output int         error_total_o,
  output int         beats_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    RX_HUNT, RX_OPEN, RX_CHECK, RX_DEST, RX_SOURCE, RX_PORT, RX_DATA, RX_DATA_ESC
  } rx_phase_e;

  rx_phase_e   phase;
  logic [7:0]  esc_code, hdr_code, close_code, board_addr;
  logic [7:0]  csum;
  int unsigned fill;
  logic [7:0]  store [MAX_PAYLOAD];
  logic [7:0]  src_id, port_num;
  logic [7:0]  rcv_total, acc_total, mis_total;
  epr_out_t    beats_due [$];
  int          faults = 0;
  int          owed = 0;

  assign error_total_o = faults;
  assign beats_owed_o  = owed;

  task automatic report_mismatch(input string what);
    faults = faults + 1;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string field, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0d, expected %0d", field, got, want));
  endtask

  task automatic clear_totals();
    rcv_total = '0;
    acc_total = '0;
    mis_total = '0;
  endtask

  function automatic epr_out_t make_beat(input event_kind_e kind, input logic [7:0] data,
                                         input int unsigned idx, input int unsigned len,
                                         input logic is_last);
    epr_out_t r;
    r.event_kind     = kind;
    r.payload_byte   = data;
    r.byte_index     = 5'(idx);
    r.payload_length = 5'(len);
    r.source_id      = src_id;
    r.port_id        = port_num;
    r.last           = is_last;
    r.received_count = rcv_total;
    r.accepted_count = acc_total;
    r.mismatch_count = mis_total;
    return r;
  endfunction

  // Advances the deframer by one received byte and queues the beats it causes.
  task automatic deframe(input epr_in_t beat);
    event_kind_e kind;
    logic [7:0]  b;
    int unsigned n;
    int unsigned i;
    kind = EV_NONE;
    b = beat.rx_byte;
    if (beat.framing_error || beat.overrun_error) begin
      phase = RX_HUNT;
    end else begin
      case (phase)
        RX_HUNT: begin
          if (b == esc_code) phase = RX_OPEN;
        end
        RX_OPEN: begin
          if (b == hdr_code) begin
            phase = RX_CHECK;
            rcv_total = rcv_total + 8'd1;
            if (rcv_total == 8'd0) clear_totals();
          end else begin
            phase = RX_HUNT;
          end
        end
        RX_CHECK: begin
          if (b == esc_code) begin
            phase = RX_OPEN;
          end else begin
            csum = ~b;
            phase = RX_DEST;
          end
        end
        RX_DEST: begin
          // The address match is tested before the escape.
          if (b == board_addr) begin
            csum = csum ^ b;
            phase = RX_SOURCE;
          end else if (b == esc_code) begin
            phase = RX_OPEN;
          end else begin
            phase = RX_HUNT;
          end
        end
        RX_SOURCE: begin
          if (b == esc_code) begin
            phase = RX_OPEN;
          end else begin
            csum = csum ^ b;
            src_id = b;
            fill = 0;
            phase = RX_PORT;
          end
        end
        RX_PORT: begin
          if (b == esc_code) begin
            phase = RX_OPEN;
          end else begin
            csum = csum ^ b;
            port_num = b;
            phase = RX_DATA;
          end
        end
        RX_DATA: begin
          if (fill < MAX_PAYLOAD) begin
            store[fill] = b;
            fill = fill + 1;
            if (b == esc_code) phase = RX_DATA_ESC;
            else csum = csum ^ b;
          end else begin
            phase = RX_HUNT;
          end
        end
        default: begin
          if (b == esc_code) begin
            csum = csum ^ b;
            phase = RX_DATA;
          end else if (b == close_code) begin
            if (csum == 8'd0) begin
              // The closing escape was stored but is not payload.
              if (fill > 0) fill = fill - 1;
              acc_total = acc_total + 8'd1;
              if (acc_total == 8'd0) clear_totals();
              kind = (fill != 0) ? EV_BYTE : EV_EMPTY;
            end else begin
              mis_total = mis_total + 8'd1;
              if (mis_total == 8'd0) clear_totals();
              kind = EV_MISMATCH;
            end
            phase = RX_HUNT;
          end else begin
            phase = RX_HUNT;
          end
        end
      endcase
    end

    if (kind == EV_BYTE) begin
      n = (fill > MAX_PAYLOAD) ? MAX_PAYLOAD : fill;
      for (i = 0; i < n; i++) beats_due.push_back(make_beat(EV_BYTE, store[i], i, n, i + 1 == n));
    end else begin
      beats_due.push_back(make_beat(kind, 8'd0, 0, 0, 1'b1));
    end
  endtask

  task automatic compare_beat(input epr_out_t got);
    epr_out_t want;
    if (beats_due.size() == 0) begin
      report_mismatch("result beat arrived with nothing expected");
    end else begin
      want = beats_due.pop_front();
      check_field("event_kind", got.event_kind, want.event_kind);
      check_field("payload_byte", got.payload_byte, want.payload_byte);
      check_field("byte_index", got.byte_index, want.byte_index);
      check_field("payload_length", got.payload_length, want.payload_length);
      check_field("source_id", got.source_id, want.source_id);
      check_field("port_id", got.port_id, want.port_id);
      check_field("last", got.last, want.last);
      check_field("received_count", got.received_count, want.received_count);
      check_field("accepted_count", got.accepted_count, want.accepted_count);
      check_field("mismatch_count", got.mismatch_count, want.mismatch_count);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_code   = ESCAPE_RESET;
      hdr_code   = HEADER_RESET;
      close_code = END_RESET;
      board_addr = ADDRESS_RESET;
      phase      = RX_HUNT;
      csum       = '0;
      fill       = 0;
      src_id     = '0;
      port_num   = '0;
      clear_totals();
      beats_due.delete();
    end else begin
      if (out_valid_i && out_ready_i) compare_beat(out_data_i);
      if (cfg_we_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_ESCAPE:  esc_code   = cfg_data_i;
          CFG_HEADER:  hdr_code   = cfg_data_i;
          CFG_END:     close_code = cfg_data_i;
          CFG_ADDRESS: board_addr = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) deframe(in_data_i);
    end
    owed = beats_due.size();
  end

endmodule

### bench/escaped_packet_receiver_core_test.sv
module escaped_packet_receiver_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import epr_pkg::*;

  localparam int unsigned MAX_PAYLOAD = 32;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 64;
  localparam int HEADER_STORM   = 12;

  // Ways a generated packet can be spoiled.
  localparam int FLAW_NONE       = 0;
  localparam int FLAW_CHECKSUM   = 1;
  localparam int FLAW_BAD_CLOSE  = 2;
  localparam int FLAW_ERROR_BYTE = 3;
  localparam int FLAW_WRONG_DEST = 4;
  localparam int FLAW_RESTART    = 5;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  epr_in_t    in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  epr_out_t   out_data_o;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;

  int         mismatches;
  int         beats_owed;
  bit         steady = 1'b0;
  int         quiet = 0;
  int         items_sent = 0;

  // Copies of the code registers, used to build frames.
  logic [7:0] esc = ESCAPE_RESET;
  logic [7:0] hdr = HEADER_RESET;
  logic [7:0] close_code = END_RESET;
  logic [7:0] addr = ADDRESS_RESET;

  escaped_packet_receiver_core #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  packet_stream_checker #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .error_total_o(mismatches),
    .beats_owed_o (beats_owed)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 37);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
    else quiet = quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_beat(input epr_in_t item);
    while (!steady && $urandom_range(99) < 37) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent = items_sent + 1;
  endtask

  task automatic send_byte(input logic [7:0] b);
    epr_in_t item;
    item.rx_byte = b;
    item.framing_error = 1'b0;
    item.overrun_error = 1'b0;
    send_beat(item);
  endtask

  task automatic send_noise(input int count);
    epr_in_t item;
    repeat (count) begin
      item.rx_byte       = 8'($urandom_range(255));
      item.framing_error = ($urandom_range(9) == 0);
      item.overrun_error = ($urandom_range(9) == 0);
      send_beat(item);
    end
  endtask

  // Holds the sender until every expected beat has come back.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (beats_owed != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [7:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ESCAPE:  esc = v;
      CFG_HEADER:  hdr = v;
      CFG_END:     close_code = v;
      CFG_ADDRESS: addr = v;
      default: ;
    endcase
  endtask

  task automatic send_packet(input logic [7:0] payload [$], input int flaw);
    logic [7:0] frame [$];
    logic [7:0] src, prt, sum, chk, dest, tail;
    epr_in_t    item;
    int         pos;
    // Pick source and port until the inverted checksum byte is not an escape.
    do begin
      src = 8'($urandom_range(255));
      prt = 8'($urandom_range(255));
      if (src == esc) src = ~src;
      if (prt == esc) prt = ~prt;
      sum = addr ^ src ^ prt;
      foreach (payload[i]) sum = sum ^ payload[i];
      chk = ~sum;
      if (flaw == FLAW_CHECKSUM) chk = chk ^ 8'($urandom_range(1, 255));
    end while (chk == esc);
    dest = (flaw == FLAW_WRONG_DEST) ? (addr ^ 8'($urandom_range(1, 255))) : addr;
    tail = close_code;
    if (flaw == FLAW_BAD_CLOSE) begin
      do tail = 8'($urandom_range(255)); while (tail == esc || tail == close_code);
    end
    frame.push_back(esc);
    frame.push_back(hdr);
    frame.push_back(chk);
    frame.push_back(dest);
    frame.push_back(src);
    frame.push_back(prt);
    foreach (payload[i]) begin
      frame.push_back(payload[i]);
      if (payload[i] == esc) frame.push_back(esc);
    end
    frame.push_back(esc);
    frame.push_back(tail);
    if (flaw == FLAW_RESTART) frame[$urandom_range(2, 5)] = esc;
    pos = (flaw == FLAW_ERROR_BYTE) ? $urandom_range(frame.size() - 1) : -1;
    foreach (frame[i]) begin
      item.rx_byte = frame[i];
      {item.framing_error, item.overrun_error} = (i == pos) ? 2'($urandom_range(1, 3)) : 2'b00;
      send_beat(item);
    end
  endtask

  function automatic void fill_payload(output logic [7:0] payload [$], input int n);
    payload.delete();
    repeat (n) payload.push_back(($urandom_range(5) == 0) ? esc : 8'($urandom_range(255)));
  endfunction

  task automatic random_packet();
    logic [7:0] payload [$];
    int         pick;
    int         n;
    pick = $urandom_range(19);
    n = ($urandom_range(7) == 0) ? $urandom_range(9, 31) : $urandom_range(8);
    if (pick == 0) n = MAX_PAYLOAD;
    fill_payload(payload, n);
    case (pick)
      1, 2:    send_packet(payload, FLAW_CHECKSUM);
      3:       send_packet(payload, FLAW_BAD_CLOSE);
      4:       send_packet(payload, FLAW_ERROR_BYTE);
      5:       send_packet(payload, FLAW_WRONG_DEST);
      6:       send_packet(payload, FLAW_RESTART);
      7:       send_noise($urandom_range(1, 6));
      default: send_packet(payload, FLAW_NONE);
    endcase
  endtask

  initial begin
    logic [7:0] payload [$];
    epr_in_t    item;
    logic [7:0] e, h, c, a;
    int         target;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Line errors, alone and together, on the extreme byte values and on an escape.
    item = '{rx_byte: 8'h00, framing_error: 1'b1, overrun_error: 1'b0};
    send_beat(item);
    item = '{rx_byte: 8'hFF, framing_error: 1'b0, overrun_error: 1'b1};
    send_beat(item);
    item = '{rx_byte: esc, framing_error: 1'b1, overrun_error: 1'b1};
    send_beat(item);
    send_byte(esc);
    send_byte(8'h00);
    payload.delete();
    send_packet(payload, FLAW_NONE);
    payload.push_back(esc);
    payload.push_back(8'h00);
    payload.push_back(8'hFF);
    send_packet(payload, FLAW_NONE);

    // Repeated headers restart the frame and step the received counter each time.
    send_byte(esc);
    repeat (HEADER_STORM) begin
      send_byte(hdr);
      send_byte(esc);
    end
    item = '{rx_byte: 8'h55, framing_error: 1'b1, overrun_error: 1'b0};
    send_beat(item);

    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        case (p)
          1: begin e = 8'h00; h = 8'hFF; c = 8'h01; a = 8'hFF; end
          2: begin e = 8'hFF; h = 8'h00; c = 8'hFE; a = 8'h00; end
          3: begin e = 8'h30; h = 8'h81; c = 8'h82; a = 8'h30; end
          default: begin
            e = 8'($urandom_range(255));
            h = 8'($urandom_range(255));
            do c = 8'($urandom_range(255)); while (c == e);
            a = $urandom_range(1) ? e : 8'($urandom_range(255));
          end
        endcase
        drain();
        write_reg(CFG_ESCAPE, e);
        write_reg(CFG_HEADER, h);
        write_reg(CFG_END, c);
        write_reg(CFG_ADDRESS, a);
      end
      steady = (p == 2);
      target = items_sent + PHASE_ITEMS;
      if (p == 0) begin
        fill_payload(payload, MAX_PAYLOAD);
        send_packet(payload, FLAW_NONE);
      end
      while (items_sent < target) random_packet();
    end
    steady = 1'b0;

    drain();
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
